FILE: hw/rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants and tables for the grid ray caster.
// ----------------------------------------------------------------------------
`default_nettype none

package grc_pkg;

  // map geometry and fixed point format
  localparam int unsigned MapSize   = 32;
  localparam int unsigned CoordBits = 5;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned AddrBits  = 2 * CoordBits;

  // datapath widths
  localparam int unsigned DvdBits   = 40;
  localparam int unsigned DsrBits   = 22;
  localparam int unsigned RootIn    = 48;
  localparam int unsigned RootOut   = 24;

  // numeric constants
  localparam logic [30:0] Q30One     = 31'h4000_0000;
  localparam logic [17:0] RadPerCdeg = 18'd187403;
  localparam logic [21:0] DistMax    = 22'd4194303;
  localparam logic [24:0] ShadeNum   = 25'd25067520;  // 765 * 2^15
  localparam logic [11:0] HeightMax  = 12'd2048;

  // Horner divisors of the sine and cosine polynomials
  function automatic logic [7:0] horner_div(input logic is_cos, input logic [2:0] idx);
    logic [7:0] d;
    d = 8'd1;
    if (is_cos) begin
      case (idx)
        3'd0: d = 8'd132;
        3'd1: d = 8'd90;
        3'd2: d = 8'd56;
        3'd3: d = 8'd30;
        3'd4: d = 8'd12;
        3'd5: d = 8'd2;
        default: d = 8'd1;
      endcase
    end else begin
      case (idx)
        3'd0: d = 8'd110;
        3'd1: d = 8'd72;
        3'd2: d = 8'd42;
        3'd3: d = 8'd20;
        3'd4: d = 8'd6;
        default: d = 8'd1;
      endcase
    end
    return d;
  endfunction

  // Reciprocals floor(2^(32+sh)/d) of the Horner divisors; the quotient
  // estimate is at most one low for any 32-bit dividend
  function automatic logic [31:0] horner_rcp(input logic is_cos, input logic [2:0] idx);
    logic [31:0] m;
    m = 32'hFFFF_FFFF;
    if (is_cos) begin
      case (idx)
        3'd0: m = 32'd4164816771;
        3'd1: m = 32'd3054198966;
        3'd2: m = 32'd2454267026;
        3'd3: m = 32'd2290649224;
        3'd4: m = 32'd2863311530;
        3'd5: m = 32'd2147483648;
        default: m = 32'hFFFF_FFFF;
      endcase
    end else begin
      case (idx)
        3'd0: m = 32'd2498890063;
        3'd1: m = 32'd3817748707;
        3'd2: m = 32'd3272356035;
        3'd3: m = 32'd3435973836;
        3'd4: m = 32'd2863311530;
        default: m = 32'hFFFF_FFFF;
      endcase
    end
    return m;
  endfunction

  // extra right shift beyond 32 that goes with each reciprocal
  function automatic logic [2:0] horner_sh(input logic is_cos, input logic [2:0] idx);
    logic [2:0] s;
    s = 3'd0;
    if (is_cos) begin
      case (idx)
        3'd0: s = 3'd7;
        3'd1: s = 3'd6;
        3'd2: s = 3'd5;
        3'd3: s = 3'd4;
        3'd4: s = 3'd3;
        3'd5: s = 3'd0;
        default: s = 3'd0;
      endcase
    end else begin
      case (idx)
        3'd0: s = 3'd6;
        3'd1: s = 3'd6;
        3'd2: s = 3'd5;
        3'd3: s = 3'd4;
        3'd4: s = 3'd2;
        default: s = 3'd0;
      endcase
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/grc_ram.sv
// ----------------------------------------------------------------------------
// grc_ram
// Single port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and read the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/grc_div.sv
// ----------------------------------------------------------------------------
// grc_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [grc_pkg::DvdBits-1:0]  dividend_i,
  input  wire logic [grc_pkg::DsrBits-1:0]  divisor_i,
  output logic                              done_o,
  output logic      [grc_pkg::DvdBits-1:0]  quot_o
);

  localparam int unsigned CntBits = $clog2(grc_pkg::DvdBits + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CntBits-1:0]          cnt_q;
  logic [grc_pkg::DvdBits-1:0] quot_q;
  logic [grc_pkg::DsrBits:0]   rem_q;
  logic [grc_pkg::DsrBits-1:0] dsr_q;
  logic [grc_pkg::DsrBits:0]   rem_sh;
  logic                        fits;

  // shift in the next dividend bit and trial subtract
  assign rem_sh = {rem_q[grc_pkg::DsrBits-1:0], quot_q[grc_pkg::DvdBits-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntBits'(grc_pkg::DvdBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      dsr_q  <= divisor_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? rem_sh - {1'b0, dsr_q} : rem_sh;
      quot_q <= {quot_q[grc_pkg::DvdBits-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: hw/rtl/grc_isqrt.sv
// ----------------------------------------------------------------------------
// grc_isqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_isqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [grc_pkg::RootIn-1:0]   val_i,
  output logic                              done_o,
  output logic      [grc_pkg::RootOut-1:0]  root_o
);

  localparam int unsigned CntBits = $clog2(grc_pkg::RootOut + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [CntBits-1:0]         cnt_q;
  logic [grc_pkg::RootIn-1:0] v_q;
  logic [grc_pkg::RootIn-1:0] res_q;
  logic [grc_pkg::RootIn-1:0] bit_q;
  logic [grc_pkg::RootIn-1:0] trial;
  logic                       take;

  assign trial = res_q + bit_q;
  assign take  = v_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntBits'(grc_pkg::RootOut - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // subtract the trial square when it fits, advance the bit pair
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
      bit_q <= grc_pkg::RootIn'(1) << (grc_pkg::RootIn - 2);
    end else if (busy_q) begin
      if (take) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[grc_pkg::RootOut-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/grid_raycast_column.sv
// ----------------------------------------------------------------------------
// grid_raycast_column
// Grid ray caster for one screen column: keeps a 32x32 wall map in RAM and
// walks a ray cell by cell from the viewer to the first wall or the map border.
//
//   channel   dir  handshake              payload
//   in        in   in_valid_i/in_ready_o  func, cell_x, cell_y, cell_wall, ray_angle
//   out       out  out_valid_o/out_ready_i hit_x, hit_y, hit_side, edge_hit,
//                                          distance, span_start, span_end, shade
//   cfg       in   cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A cast runs three divisions on the shared divider (offset, span, shade),
// a square root and the eleven sine and cosine Horner terms. A zero
// distance skips the span and shade divisions. After reset a pass over all
// 1024 entries clears the map RAM before the first word is taken. A waiting
// result holds in the output register; the next word is taken while it
// waits.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_raycast_column (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [20:0] cfg_wdata_i,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [4:0]  cell_x_i,
  input  wire logic [4:0]  cell_y_i,
  input  wire logic        cell_wall_i,
  input  wire logic [15:0] ray_angle_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       hit_x_o,
  output logic [4:0]       hit_y_o,
  output logic             hit_side_o,
  output logic             edge_hit_o,
  output logic [21:0]      distance_o,
  output logic [10:0]      span_start_o,
  output logic [10:0]      span_end_o,
  output logic [7:0]       shade_o
);

  localparam logic [1:0] RegPosX   = 2'd0;
  localparam logic [1:0] RegPosY   = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;
  localparam logic       FuncWrite = 1'b0;
  localparam logic [4:0] CoordMax  = 5'(grc_pkg::MapSize - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_X, S_X2, S_HMUL, S_HREC, S_HFIX, S_HUPD, S_SMUL, S_ROT,
    S_RD, S_CHK, S_MUL2, S_STEP, S_FMUL, S_FDIV, S_SQ1, S_SQ2,
    S_SQS, S_SQRT, S_LDS, S_LDIV, S_SDS, S_SDIV, S_OUT
  } state_e;

  state_e        state_q;
  logic [9:0]    clr_cnt_q;
  logic [20:0]   pos_x_q, pos_y_q;
  logic [11:0]   height_q;
  logic [1:0]    quad_q;
  logic [13:0]   t_q;
  logic [30:0]   x_q;
  logic [31:0]   x2_q;
  logic [30:0]   r_q;
  logic [31:0]   n_q;
  logic [31:0]   q_q;
  logic [16:0]   s_q;
  logic          cos_q;
  logic [2:0]    hidx_q;
  logic [16:0]   ax_q, ay_q;
  logic          negx_q, negy_q;
  logic [4:0]    mx_q, my_q;
  logic [22:0]   nx_q, ny_q, used_q, ex_q, ey_q;
  logic [39:0]   p1_q, p2_q;
  logic          side_q, edge_q;
  logic [47:0]   sum_q;
  logic [21:0]   dist_q;
  logic [27:0]   lh_q;
  logic [7:0]    shade_q;
  logic          out_valid_q;

  logic          in_acc;
  logic [15:0]   ang_red;
  logic [1:0]    quad_d;
  logic [15:0]   t_d;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic          div_start;
  logic [39:0]   div_dvd;
  logic [21:0]   div_dsr;
  logic          div_done;
  logic [39:0]   div_quot;
  logic          sq_done;
  logic [23:0]   sq_root;
  logic          ram_we;
  logic [9:0]    ram_addr;
  logic          ram_wdata;
  logic          ram_rdata;
  logic [16:0]   c_rnd, s_rnd;
  logic [31:0]   sv_sum;
  logic [16:0]   den;
  logic          xstep;
  logic          hlast;
  logic [7:0]    hdiv;
  logic [31:0]   hrem;
  logic          hfits;
  logic [11:0]   h_eff;
  logic [10:0]   half;
  logic [26:0]   lh2;
  logic [27:0]   end_sum;

  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;

  // reduce the angle to a quadrant and an offset within it
  always_comb begin
    ang_red = (ray_angle_i >= 16'd36000) ? ray_angle_i - 16'd36000 : ray_angle_i;
    if (ang_red >= 16'd27000) begin
      quad_d = 2'd3;
      t_d    = ang_red - 16'd27000;
    end else if (ang_red >= 16'd18000) begin
      quad_d = 2'd2;
      t_d    = ang_red - 16'd18000;
    end else if (ang_red >= 16'd9000) begin
      quad_d = 2'd1;
      t_d    = ang_red - 16'd9000;
    end else begin
      quad_d = 2'd0;
      t_d    = ang_red;
    end
  end

  assign hdiv = grc_pkg::horner_div(cos_q, hidx_q);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_X: begin
        mul_a = 32'(t_q);
        mul_b = 32'(grc_pkg::RadPerCdeg);
      end
      S_X2: begin
        mul_a = 32'(x_q);
        mul_b = 32'(x_q);
      end
      S_HMUL: begin
        mul_a = x2_q;
        mul_b = 32'(r_q);
      end
      S_HREC: begin
        mul_a = n_q;
        mul_b = grc_pkg::horner_rcp(cos_q, hidx_q);
      end
      S_HFIX: begin
        mul_a = q_q;
        mul_b = 32'(hdiv);
      end
      S_SMUL: begin
        mul_a = 32'(x_q);
        mul_b = 32'(r_q);
      end
      S_CHK: begin
        mul_a = 32'(nx_q);
        mul_b = 32'(ay_q);
      end
      S_MUL2: begin
        mul_a = 32'(ny_q);
        mul_b = 32'(ax_q);
      end
      S_FMUL: begin
        mul_a = 32'(used_q);
        mul_b = side_q ? 32'(ax_q) : 32'(ay_q);
      end
      S_SQ1: begin
        mul_a = 32'(ex_q);
        mul_b = 32'(ex_q);
      end
      S_SQ2: begin
        mul_a = 32'(ey_q);
        mul_b = 32'(ey_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // correct the reciprocal quotient estimate by one compare
  assign hrem  = n_q - prod[31:0];
  assign hfits = hrem >= 32'(hdiv);

  // effective screen height, clamped to 1..2048
  always_comb begin
    if (height_q == '0) begin
      h_eff = 12'd1;
    end else if (height_q > grc_pkg::HeightMax) begin
      h_eff = grc_pkg::HeightMax;
    end else begin
      h_eff = height_q;
    end
  end

  assign den = side_q ? ay_q : ax_q;

  // divider requests
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    case (state_q)
      S_FMUL: begin
        div_start = 1'b1;
        div_dvd   = prod[39:0];
        div_dsr   = 22'(den);
      end
      S_LDS: begin
        div_start = dist_q != '0;
        div_dvd   = {12'd0, h_eff, 16'd0};
        div_dsr   = dist_q;
      end
      S_SDS: begin
        div_start = 1'b1;
        div_dvd   = 40'(grc_pkg::ShadeNum);
        div_dsr   = dist_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  grc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_SQS),
    .val_i   (sum_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // map RAM port: clearing pass, cell writes, ray walk reads
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = {my_q, mx_q};
    if (state_q == S_CLR) begin
      ram_we   = 1'b1;
      ram_addr = clr_cnt_q;
    end else if (state_q == S_IDLE) begin
      ram_we    = in_acc && (func_i == FuncWrite);
      ram_wdata = cell_wall_i;
      ram_addr  = {cell_y_i, cell_x_i};
    end
  end

  grc_ram #(
    .WIDTH (1),
    .DEPTH (grc_pkg::MapSize * grc_pkg::MapSize)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // rounding of the Q30 polynomial results to Q16
  assign c_rnd  = 17'((r_q + 31'd8192) >> 14);
  assign sv_sum = 32'(prod[60:30]) + 32'd8192;
  assign s_rnd  = 17'(sv_sum >> 14);
  assign hlast  = cos_q ? (hidx_q == 3'd5) : (hidx_q == 3'd4);

  // step choice: x on a tie
  assign xstep = (ax_q != '0) && ((ay_q == '0) || (p1_q <= p2_q));

  // span arithmetic
  assign half    = h_eff[11:1];
  assign lh2     = lh_q[27:1];
  assign end_sum = 28'(half) + 28'(lh2);

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      pos_x_q     <= 21'd786432;
      pos_y_q     <= 21'd786432;
      height_q    <= 12'd1080;
      out_valid_q <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPosX:   pos_x_q  <= cfg_wdata_i;
          RegPosY:   pos_y_q  <= cfg_wdata_i;
          RegHeight: height_q <= cfg_wdata_i[11:0];
          default:   ;
        endcase
      end

      // drop a taken result unless a new one replaces it
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (func_i != FuncWrite)) begin
            state_q <= S_X;
          end
        end
        S_X:    state_q <= S_X2;
        S_X2:   state_q <= S_HMUL;
        S_HMUL: state_q <= S_HREC;
        S_HREC: state_q <= S_HFIX;
        S_HFIX: state_q <= S_HUPD;
        S_HUPD: begin
          if (hlast) begin
            state_q <= cos_q ? S_ROT : S_SMUL;
          end else begin
            state_q <= S_HMUL;
          end
        end
        S_SMUL: state_q <= S_HMUL;
        S_ROT:  state_q <= S_RD;
        S_RD:   state_q <= S_CHK;
        S_CHK:  state_q <= ram_rdata ? S_FMUL : S_MUL2;
        S_MUL2: state_q <= S_STEP;
        S_STEP: begin
          if (xstep) begin
            state_q <= (negx_q ? (mx_q == '0) : (mx_q == CoordMax)) ? S_FMUL : S_RD;
          end else begin
            state_q <= (negy_q ? (my_q == '0) : (my_q == CoordMax)) ? S_FMUL : S_RD;
          end
        end
        S_FMUL: state_q <= S_FDIV;
        S_FDIV: begin
          if (div_done) begin
            state_q <= S_SQ1;
          end
        end
        S_SQ1:  state_q <= S_SQ2;
        S_SQ2:  state_q <= S_SQS;
        S_SQS:  state_q <= S_SQRT;
        S_SQRT: begin
          if (sq_done) begin
            state_q <= S_LDS;
          end
        end
        S_LDS:  state_q <= (dist_q == '0) ? S_OUT : S_LDIV;
        S_LDIV: begin
          if (div_done) begin
            state_q <= S_SDS;
          end
        end
        S_SDS:  state_q <= S_SDIV;
        S_SDIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        quad_q <= quad_d;
        t_q    <= t_d[13:0];
      end
      S_X: begin
        x_q <= prod[30:0];
      end
      S_X2: begin
        x2_q   <= prod[61:30];
        r_q    <= grc_pkg::Q30One;
        cos_q  <= 1'b0;
        hidx_q <= '0;
      end
      S_HMUL: begin
        n_q <= prod[61:30];
      end
      S_HREC: begin
        q_q <= prod[63:32] >> grc_pkg::horner_sh(cos_q, hidx_q);
      end
      S_HFIX: begin
        q_q <= q_q + 32'(hfits);
      end
      S_HUPD: begin
        r_q    <= (q_q > 32'(grc_pkg::Q30One)) ? '0
                : grc_pkg::Q30One - q_q[30:0];
        hidx_q <= hidx_q + 1'b1;
      end
      S_SMUL: begin
        s_q    <= s_rnd;
        r_q    <= grc_pkg::Q30One;
        cos_q  <= 1'b1;
        hidx_q <= '0;
      end
      S_ROT: begin
        // rotate the first-quadrant direction into place
        case (quad_q)
          2'd0: begin
            ax_q <= c_rnd; ay_q <= s_q; negx_q <= 1'b0; negy_q <= 1'b0;
          end
          2'd1: begin
            ax_q <= s_q; ay_q <= c_rnd; negx_q <= 1'b1; negy_q <= 1'b0;
          end
          2'd2: begin
            ax_q <= c_rnd; ay_q <= s_q; negx_q <= 1'b1; negy_q <= 1'b1;
          end
          default: begin
            ax_q <= s_q; ay_q <= c_rnd; negx_q <= 1'b0; negy_q <= 1'b1;
          end
        endcase
        mx_q   <= pos_x_q[20:16];
        my_q   <= pos_y_q[20:16];
        nx_q   <= (quad_q == 2'd1 || quad_q == 2'd2) ? 23'(pos_x_q[15:0])
                : 23'(17'h10000 - 17'(pos_x_q[15:0]));
        ny_q   <= (quad_q == 2'd2 || quad_q == 2'd3) ? 23'(pos_y_q[15:0])
                : 23'(17'h10000 - 17'(pos_y_q[15:0]));
        side_q <= 1'b0;
        edge_q <= 1'b0;
        used_q <= '0;
      end
      S_CHK: begin
        p1_q <= prod[39:0];
      end
      S_MUL2: begin
        p2_q <= prod[39:0];
      end
      S_STEP: begin
        // advance one cell, or stop at the map border
        if (xstep) begin
          side_q <= 1'b0;
          used_q <= nx_q;
          nx_q   <= nx_q + 23'h10000;
          if (negx_q ? (mx_q == '0) : (mx_q == CoordMax)) begin
            edge_q <= 1'b1;
          end else begin
            mx_q <= negx_q ? mx_q - 1'b1 : mx_q + 1'b1;
          end
        end else begin
          side_q <= 1'b1;
          used_q <= ny_q;
          ny_q   <= ny_q + 23'h10000;
          if (negy_q ? (my_q == '0) : (my_q == CoordMax)) begin
            edge_q <= 1'b1;
          end else begin
            my_q <= negy_q ? my_q - 1'b1 : my_q + 1'b1;
          end
        end
      end
      S_FDIV: begin
        if (div_done) begin
          if (side_q) begin
            ey_q <= used_q;
            ex_q <= (den == '0) ? '0 : div_quot[22:0];
          end else begin
            ex_q <= used_q;
            ey_q <= (den == '0) ? '0 : div_quot[22:0];
          end
        end
      end
      S_SQ1: begin
        sum_q <= prod[47:0];
      end
      S_SQ2: begin
        sum_q <= sum_q + prod[47:0];
      end
      S_SQRT: begin
        if (sq_done) begin
          dist_q <= (sq_root > 24'(grc_pkg::DistMax)) ? grc_pkg::DistMax : sq_root[21:0];
        end
      end
      S_LDS: begin
        if (dist_q == '0) begin
          lh_q    <= '0;
          shade_q <= 8'd255;
        end
      end
      S_LDIV: begin
        if (div_done) begin
          lh_q <= div_quot[27:0];
        end
      end
      S_SDIV: begin
        if (div_done) begin
          shade_q <= (div_quot > 40'd255) ? 8'd255 : div_quot[7:0];
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          hit_x_o      <= mx_q;
          hit_y_o      <= my_q;
          hit_side_o   <= side_q;
          edge_hit_o   <= edge_q;
          distance_o   <= dist_q;
          span_start_o <= (27'(half) > lh2) ? half - lh2[10:0] : '0;
          span_end_o   <= (end_sum >= 28'(h_eff)) ? 11'(h_eff - 12'd1) : end_sum[10:0];
          shade_o      <= shade_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
